### rtl/core/mkv_pkg.sv
package mkv_pkg;

   localparam int MAX_CAP     = 2047;
   localparam int TABLE_DEPTH = MAX_CAP + 1;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   localparam int CAP_W    = 11;
   localparam int WEIGHT_W = 11;
   localparam int GAIN_W   = 16;
   localparam int COPIES_W = 10;
   localparam int VALUE_W  = 32;

   // one binary piece: count times weight and count times gain
   localparam int PWEIGHT_W = WEIGHT_W + COPIES_W;
   localparam int PGAIN_W   = GAIN_W + COPIES_W;
   localparam int POW_W     = COPIES_W + 1;

   typedef struct packed {
      logic                rd;
      logic                upd;
      logic [ADDR_W-1:0]   lo_addr;
      logic [ADDR_W-1:0]   hi_addr;
      logic [PGAIN_W-1:0]  gain;
      logic                clr;
      logic [ADDR_W-1:0]   clr_addr;
   } mkv_issue_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [VALUE_W-1:0]  data;
   } mkv_write_type;

endpackage

### rtl/core/mkv_ifs.sv
interface mkv_req_if;
   import mkv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WEIGHT_W-1:0]   weight;
   logic [GAIN_W-1:0]     gain;
   logic [COPIES_W-1:0]   copies;
   logic                  last_item;

   modport source (output valid, weight, gain, copies, last_item, input ready);
   modport sink   (input valid, weight, gain, copies, last_item, output ready);
endinterface

interface mkv_rsp_if;
   import mkv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [VALUE_W-1:0]    best_value;

   modport source (output valid, best_value, input ready);
   modport sink   (input valid, best_value, output ready);
endinterface

interface mkv_csr_if;
   import mkv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CAP_W-1:0]      capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

### rtl/core/mixed_knapsack_max_value_core.sv
// channel   direction  accepted when          carries
// req_bus   in         valid && ready         weight, gain, copies, last_item
// rsp_bus   out        valid && ready         best_value
// csr_bus   in         valid (ready is high)  capacity
//
// an item steps through S_PIECE and S_SETUP for each binary piece; a piece that fits sweeps cap - piece
// weight + 1 table entries, one table entry a cycle through the read-modify-write loop around
// the table memory; a copy count n gives about log2(n) + 1 pieces
// the item marked last then reads the result and clears all 2048 table entries
// reset (synchronous) starts the same clearing pass; req_bus is not ready
// until it ends; a stalled result holds in the output register while clearing runs
module mixed_knapsack_max_value_core (
   input  logic        clock,
   input  logic        reset,
   mkv_req_if.sink     req_bus,
   mkv_rsp_if.source   rsp_bus,
   mkv_csr_if.sink     csr_bus
);
   import mkv_pkg::*;

   mkv_issue_type       issue;
   mkv_write_type       wr;
   logic [VALUE_W-1:0]  lo_data;
   logic [VALUE_W-1:0]  hi_data;
   logic [VALUE_W-1:0]  hi_value;

   mkv_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_bus  (csr_bus),
      .hi_value (hi_value),
      .issue    (issue)
   );

   mkv_table u_table (
      .clock   (clock),
      .issue   (issue),
      .wr      (wr),
      .lo_data (lo_data),
      .hi_data (hi_data)
   );

   mkv_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .lo_data  (lo_data),
      .hi_data  (hi_data),
      .wr       (wr),
      .hi_value (hi_value)
   );

endmodule

### rtl/core/mkv_table.sv
module mkv_table (
   input  logic                          clock,
   input  mkv_pkg::mkv_issue_type        issue,
   input  mkv_pkg::mkv_write_type        wr,
   output logic [mkv_pkg::VALUE_W-1:0]   lo_data,
   output logic [mkv_pkg::VALUE_W-1:0]   hi_data
);
   import mkv_pkg::*;

   logic [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic [VALUE_W-1:0] lo_data_ff;
   logic [VALUE_W-1:0] hi_data_ff;

   // read returns the old entry when the same address is written in that cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      lo_data_ff <= mem[issue.lo_addr];
      hi_data_ff <= mem[issue.hi_addr];
   end

   assign lo_data = lo_data_ff;
   assign hi_data = hi_data_ff;

endmodule

### rtl/core/mkv_fold.sv
module mkv_fold (
   input  logic                          clock,
   input  logic                          reset,
   input  mkv_pkg::mkv_issue_type        issue,
   input  logic [mkv_pkg::VALUE_W-1:0]   lo_data,
   input  logic [mkv_pkg::VALUE_W-1:0]   hi_data,
   output mkv_pkg::mkv_write_type        wr,
   output logic [mkv_pkg::VALUE_W-1:0]   hi_value
);
   import mkv_pkg::*;

   logic                 b_valid_ff, b_valid_in;
   logic                 b_upd_ff, b_upd_in;
   logic [ADDR_W-1:0]    b_lo_ff, b_lo_in;
   logic [ADDR_W-1:0]    b_hi_ff, b_hi_in;
   logic [PGAIN_W-1:0]   b_gain_ff, b_gain_in;

   logic                 fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]    fwd_addr_ff, fwd_addr_in;
   logic [VALUE_W-1:0]   fwd_data_ff, fwd_data_in;

   logic [VALUE_W-1:0]   lo_val;
   logic [VALUE_W-1:0]   hi_val;
   logic [VALUE_W:0]     sum;
   logic [VALUE_W-1:0]   cand;
   logic                 improve;

   always_comb begin
      b_valid_in = issue.rd;
      b_upd_in   = issue.upd;
      b_lo_in    = issue.lo_addr;
      b_hi_in    = issue.hi_addr;
      b_gain_in  = issue.gain;
   end

   // a write in the read cycle is not seen by the memory output
   always_comb begin
      lo_val = (fwd_valid_ff && fwd_addr_ff == b_lo_ff) ? fwd_data_ff : lo_data;
      hi_val = (fwd_valid_ff && fwd_addr_ff == b_hi_ff) ? fwd_data_ff : hi_data;
      sum    = {1'b0, lo_val} + (VALUE_W + 1)'(b_gain_ff);
      cand   = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
      improve = b_valid_ff && b_upd_ff && (cand > hi_val);
   end

   always_comb begin
      if (issue.clr) begin
         wr.en   = 1'b1;
         wr.addr = issue.clr_addr;
         wr.data = '0;
      end else begin
         wr.en   = improve;
         wr.addr = b_hi_ff;
         wr.data = cand;
      end
      fwd_valid_in = wr.en;
      fwd_addr_in  = wr.addr;
      fwd_data_in  = wr.data;
   end

   assign hi_value = hi_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         b_upd_ff     <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         b_upd_ff     <= b_upd_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      b_lo_ff     <= b_lo_in;
      b_hi_ff     <= b_hi_in;
      b_gain_ff   <= b_gain_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

endmodule

### rtl/core/mkv_seq.sv
module mkv_seq (
   input  logic                          clock,
   input  logic                          reset,
   mkv_req_if.sink                       req_bus,
   mkv_rsp_if.source                     rsp_bus,
   mkv_csr_if.sink                       csr_bus,
   input  logic [mkv_pkg::VALUE_W-1:0]   hi_value,
   output mkv_pkg::mkv_issue_type        issue
);
   import mkv_pkg::*;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_PIECE    = 3'd2;
   localparam logic [2:0] S_SETUP    = 3'd3;
   localparam logic [2:0] S_SWEEP    = 3'd4;
   localparam logic [2:0] S_RES_RD   = 3'd5;
   localparam logic [2:0] S_RES_WAIT = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CAP_W-1:0]      capacity_ff, capacity_in;
   logic [ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;

   logic [WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic                  last_ff, last_in;
   logic                  asc_ff, asc_in;
   logic [COPIES_W-1:0]   left_ff, left_in;
   logic [POW_W-1:0]      pow_ff, pow_in;

   logic [PWEIGHT_W-1:0]  pweight_ff, pweight_in;
   logic [PGAIN_W-1:0]    pgain_ff, pgain_in;
   logic [ADDR_W-1:0]     w_ff, w_in;
   logic [ADDR_W-1:0]     j_ff, j_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]     limit;
   logic [COPIES_W-1:0]   cnt;
   logic                  sweep_end;
   logic                  out_free;

   assign limit = (32'(capacity_ff) > MAX_CAP) ? ADDR_W'(MAX_CAP) : ADDR_W'(capacity_ff);

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.best_value = rsp_data_ff;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign sweep_end = asc_ff ? (j_ff == limit) : (j_ff == w_ff);

   always_comb begin
      state_in     = state_ff;
      capacity_in  = csr_bus.valid ? csr_bus.capacity : capacity_ff;
      clr_cnt_in   = clr_cnt_ff;
      weight_in    = weight_ff;
      gain_in      = gain_ff;
      last_in      = last_ff;
      asc_in       = asc_ff;
      left_in      = left_ff;
      pow_in       = pow_ff;
      pweight_in   = pweight_ff;
      pgain_in     = pgain_ff;
      w_in         = w_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      cnt          = '0;

      issue          = '0;
      issue.lo_addr  = j_ff - w_ff;
      issue.hi_addr  = j_ff;
      issue.gain     = pgain_ff;
      issue.clr_addr = clr_cnt_ff;

      unique case (state_ff)
         S_CLEAR: begin
            issue.clr  = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               weight_in = req_bus.weight;
               gain_in   = req_bus.gain;
               last_in   = req_bus.last_item;
               asc_in    = (req_bus.copies == '0);
               // unlimited and single items fold as one piece of count one
               left_in   = (req_bus.copies == '0) ? COPIES_W'(1) : req_bus.copies;
               pow_in    = POW_W'(1);
               state_in  = S_PIECE;
            end
         end
         S_PIECE: begin
            if (pow_ff <= POW_W'(left_ff)) begin
               cnt      = pow_ff[COPIES_W-1:0];
               left_in  = left_ff - pow_ff[COPIES_W-1:0];
               pow_in   = {pow_ff[POW_W-2:0], 1'b0};
               state_in = S_SETUP;
            end else if (left_ff != '0) begin
               cnt      = left_ff;
               left_in  = '0;
               state_in = S_SETUP;
            end else begin
               state_in = last_ff ? S_RES_RD : S_IDLE;
            end
            pweight_in = PWEIGHT_W'(weight_ff * cnt);
            pgain_in   = PGAIN_W'(gain_ff * cnt);
         end
         S_SETUP: begin
            // zero weight or a piece heavier than the budget changes nothing
            if (pweight_ff == '0 || pweight_ff > PWEIGHT_W'(limit)) begin
               state_in = S_PIECE;
            end else begin
               w_in     = pweight_ff[ADDR_W-1:0];
               j_in     = asc_ff ? pweight_ff[ADDR_W-1:0] : limit;
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            issue.rd  = 1'b1;
            issue.upd = 1'b1;
            if (sweep_end) begin
               state_in = S_PIECE;
            end else begin
               j_in = asc_ff ? j_ff + 1'b1 : j_ff - 1'b1;
            end
         end
         S_RES_RD: begin
            issue.lo_addr = limit;
            issue.hi_addr = limit;
            if (out_free) begin
               issue.rd = 1'b1;
               state_in = S_RES_WAIT;
            end
         end
         S_RES_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = hi_value;
            clr_cnt_in   = '0;
            state_in     = S_CLEAR;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         capacity_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      weight_ff   <= weight_in;
      gain_ff     <= gain_in;
      last_ff     <= last_in;
      asc_ff      <= asc_in;
      left_ff     <= left_in;
      pow_ff      <= pow_in;
      pweight_ff  <= pweight_in;
      pgain_ff    <= pgain_in;
      w_ff        <= w_in;
      j_ff        <= j_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
